FILE: hw/rtl/rne_pkg.sv
// ----------------------------------------------------------------------------
// rne_pkg
// Shared types, letter codes and digit helpers for the Roman numeral encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rne_pkg;

    localparam int NUM_W    = 12;
    localparam int LETTER_W = 7;

    localparam logic [NUM_W-1:0] ROMAN_MAX = 12'd3999;

    // ASCII letter codes
    localparam logic [LETTER_W-1:0] CH_I = 7'h49;
    localparam logic [LETTER_W-1:0] CH_V = 7'h56;
    localparam logic [LETTER_W-1:0] CH_X = 7'h58;
    localparam logic [LETTER_W-1:0] CH_L = 7'h4C;
    localparam logic [LETTER_W-1:0] CH_C = 7'h43;
    localparam logic [LETTER_W-1:0] CH_D = 7'h44;
    localparam logic [LETTER_W-1:0] CH_M = 7'h4D;
    localparam logic [LETTER_W-1:0] CH_NONE = 7'h00;

    // Decimal places, most significant first
    localparam logic [1:0] PL_THOU = 2'd0;
    localparam logic [1:0] PL_HUND = 2'd1;
    localparam logic [1:0] PL_TENS = 2'd2;
    localparam logic [1:0] PL_ONES = 2'd3;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } t_back_state;

    // One classified number; digit[0] holds the thousands
    typedef struct packed {
        t_status          status;
        logic [3:0][3:0]  digit;
    } t_entry;

    // Number of letters that one decimal digit expands into
    function automatic logic [2:0] dig_len(input logic [3:0] d);
        logic [2:0] len;
        if (d == 4'd9 || d == 4'd4) begin
            len = 3'd2;
        end else if (d >= 4'd5) begin
            len = 3'd1 + 3'(d - 4'd5);
        end else begin
            len = 3'(d);
        end
        return len;
    endfunction

    // Letter at position pos of digit d at decimal place pl
    function automatic logic [LETTER_W-1:0] dig_letter(input logic [3:0] d,
                                                       input logic [1:0] pos,
                                                       input logic [1:0] pl);
        logic [LETTER_W-1:0] one;
        logic [LETTER_W-1:0] five;
        logic [LETTER_W-1:0] ten;
        logic [LETTER_W-1:0] ch;
        case (pl)
            PL_THOU: begin
                one  = CH_M;
                five = CH_M;
                ten  = CH_M;
            end
            PL_HUND: begin
                one  = CH_C;
                five = CH_D;
                ten  = CH_M;
            end
            PL_TENS: begin
                one  = CH_X;
                five = CH_L;
                ten  = CH_C;
            end
            default: begin
                one  = CH_I;
                five = CH_V;
                ten  = CH_X;
            end
        endcase
        if (d == 4'd9) begin
            ch = (pos == 2'd0) ? one : ten;
        end else if (d == 4'd4) begin
            ch = (pos == 2'd0) ? one : five;
        end else if (d >= 4'd5 && pos == 2'd0) begin
            ch = five;
        end else begin
            ch = one;
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/roman_numeral_encoder_unit.sv
// ----------------------------------------------------------------------------
// roman_numeral_encoder_unit
// Converts a 12-bit number into its Roman numeral, one ASCII letter per word.
// ----------------------------------------------------------------------------
// Each accepted number yields a run of words, one letter each, most
// significant first, with o_last set on the final word; zero yields a single
// word with status empty and numbers above 3999 a single word with status
// out of range. The back end emits one word per cycle while the output is
// not stalled, so a number yields one word per letter: 1 to 15 words (15
// for 3888). The front end splits the number into decimal digits in two
// register stages and feeds a queue of QUEUE_DEPTH entries, so input is
// taken every cycle until the queue and the front stages fill; a number's
// digits go from the queue into the back end's digit and output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module roman_numeral_encoder_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [rne_pkg::NUM_W-1:0]    i_number,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [rne_pkg::LETTER_W-1:0]      o_letter,
    output logic                              o_last,
    output logic [1:0]                        o_status
);
    import rne_pkg::*;

    logic   push;
    logic   full;
    logic   pop;
    logic   empty;
    t_entry push_entry;
    t_entry head_entry;

    rne_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_number (i_number),
        .o_push   (push),
        .o_entry  (push_entry),
        .i_full   (full)
    );

    rne_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_entry (head_entry),
        .o_empty (empty)
    );

    rne_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_entry  (head_entry),
        .i_empty  (empty),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_letter (o_letter),
        .o_last   (o_last),
        .o_status (o_status)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/rne_front.sv
// ----------------------------------------------------------------------------
// rne_front
// Accepts numbers, classifies them and splits them into decimal digits over
// two pipeline stages before pushing them into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rne_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic [rne_pkg::NUM_W-1:0] i_number,
    output logic                           o_push,
    output rne_pkg::t_entry                o_entry,
    input  wire logic                      i_full
);
    import rne_pkg::*;

    logic               r_s1_v;
    logic [NUM_W-1:0]   r_s1_num;
    logic               r_s2_v;
    t_status            r_s2_status;
    logic [3:0]         r_s2_thou;
    logic [9:0]         r_s2_rem;

    logic               s1_move;
    logic               s2_move;
    logic               in_take;

    t_status            s1_status;
    logic [3:0]         s1_thou;
    logic [NUM_W-1:0]   s1_sub;

    logic [3:0]         s2_hund;
    logic [9:0]         s2_sub_h;
    logic [6:0]         s2_rem2;
    logic [3:0]         s2_tens;
    logic [6:0]         s2_sub_t;
    logic [3:0]         s2_ones;

    assign s2_move = r_s2_v && !i_full;
    assign s1_move = r_s1_v && (!r_s2_v || s2_move);
    assign o_stall = r_s1_v && !s1_move;
    assign in_take = i_valid && !o_stall;

    // Stage 1: classify and peel off the thousands
    always_comb begin
        if (r_s1_num == '0) begin
            s1_status = ST_EMPTY;
        end else if (r_s1_num > ROMAN_MAX) begin
            s1_status = ST_RANGE;
        end else begin
            s1_status = ST_OK;
        end
        if (r_s1_num >= 12'd3000) begin
            s1_thou = 4'd3;
            s1_sub  = 12'd3000;
        end else if (r_s1_num >= 12'd2000) begin
            s1_thou = 4'd2;
            s1_sub  = 12'd2000;
        end else if (r_s1_num >= 12'd1000) begin
            s1_thou = 4'd1;
            s1_sub  = 12'd1000;
        end else begin
            s1_thou = 4'd0;
            s1_sub  = 12'd0;
        end
    end

    // Stage 2: hundreds, tens and ones from the remainder below 1000
    always_comb begin
        s2_hund  = 4'd0;
        s2_sub_h = 10'd0;
        for (int k = 1; k < 10; k++) begin
            if (r_s2_rem >= 10'(k * 100)) begin
                s2_hund  = 4'(k);
                s2_sub_h = 10'(k * 100);
            end
        end
        s2_rem2  = 7'(r_s2_rem - s2_sub_h);
        s2_tens  = 4'd0;
        s2_sub_t = 7'd0;
        for (int k = 1; k < 10; k++) begin
            if (s2_rem2 >= 7'(k * 10)) begin
                s2_tens  = 4'(k);
                s2_sub_t = 7'(k * 10);
            end
        end
        s2_ones = 4'(s2_rem2 - s2_sub_t);
    end

    assign o_push                 = s2_move;
    assign o_entry.status         = r_s2_status;
    assign o_entry.digit[PL_THOU] = r_s2_thou;
    assign o_entry.digit[PL_HUND] = s2_hund;
    assign o_entry.digit[PL_TENS] = s2_tens;
    assign o_entry.digit[PL_ONES] = s2_ones;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (in_take) begin
                r_s1_v <= 1'b1;
            end else if (s1_move) begin
                r_s1_v <= 1'b0;
            end
            if (s1_move) begin
                r_s2_v <= 1'b1;
            end else if (s2_move) begin
                r_s2_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_num <= i_number;
        end
        if (s1_move) begin
            r_s2_status <= s1_status;
            r_s2_thou   <= s1_thou;
            r_s2_rem    <= 10'(r_s1_num - s1_sub);
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/rne_queue.sv
// ----------------------------------------------------------------------------
// rne_queue
// Short first-in first-out buffer of classified numbers between the front
// and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module rne_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  rne_pkg::t_entry      i_entry,
    output logic                 o_full,
    input  wire logic            i_pop,
    output rne_pkg::t_entry      o_entry,
    output logic                 o_empty
);
    import rne_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry          r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic [AW-1:0]   n_wr;
    logic [AW-1:0]   n_rd;
    logic [CW-1:0]   n_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_entry = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/rne_back.sv
// ----------------------------------------------------------------------------
// rne_back
// Walks the digits of one classified number and emits one letter per cycle,
// while the output is not stalled, into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rne_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  rne_pkg::t_entry                    i_entry,
    input  wire logic                          i_empty,
    output logic                               o_pop,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [rne_pkg::LETTER_W-1:0]       o_letter,
    output logic                               o_last,
    output logic [1:0]                         o_status
);
    import rne_pkg::*;

    t_back_state         r_state;
    t_back_state         n_state;
    t_status             r_st;
    logic [3:0][3:0]     r_dig;
    logic [1:0]          r_idx;
    logic [1:0]          r_pos;

    logic                r_out_v;
    logic [LETTER_W-1:0] r_letter;
    logic                r_last;
    t_status             r_status;

    logic                out_load;
    logic                emit;
    logic                finish;
    logic [3:0]          cur_d;
    logic [2:0]          cur_len;
    logic                at_end;
    logic                lower_zero;
    logic [1:0]          nxt_idx;
    logic [1:0]          first_idx;
    logic [LETTER_W-1:0] emit_letter;
    logic                emit_last;

    assign out_load = !r_out_v || !i_stall;
    assign emit     = (r_state == BK_RUN) && out_load;

    // Letter generation for the current digit
    always_comb begin
        cur_d      = r_dig[r_idx];
        cur_len    = dig_len(cur_d);
        at_end     = ({1'b0, r_pos} == cur_len - 3'd1);
        lower_zero = 1'b1;
        nxt_idx    = r_idx;
        for (int k = 3; k >= 0; k--) begin
            if (2'(k) > r_idx && r_dig[k] != 4'd0) begin
                lower_zero = 1'b0;
                nxt_idx    = 2'(k);
            end
        end
        first_idx = PL_ONES;
        for (int k = 3; k >= 0; k--) begin
            if (i_entry.digit[k] != 4'd0) begin
                first_idx = 2'(k);
            end
        end
        if (r_st == ST_OK) begin
            emit_letter = dig_letter(cur_d, r_pos, r_idx);
            emit_last   = at_end && lower_zero;
        end else begin
            emit_letter = CH_NONE;
            emit_last   = 1'b1;
        end
        finish = emit && emit_last;
        o_pop  = !i_empty && ((r_state == BK_IDLE) || finish);
    end

    always_comb begin
        n_state = r_state;
        if (o_pop) begin
            n_state = BK_RUN;
        end else if (finish) begin
            n_state = BK_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_v <= 1'b1;
            end else if (!i_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_st  <= i_entry.status;
            r_dig <= i_entry.digit;
            r_idx <= first_idx;
            r_pos <= 2'd0;
        end else if (emit && r_st == ST_OK) begin
            // advance to the next letter, or to the next nonzero digit
            if (at_end) begin
                r_idx <= nxt_idx;
                r_pos <= 2'd0;
            end else begin
                r_pos <= r_pos + 2'd1;
            end
        end
        if (emit) begin
            r_letter <= emit_letter;
            r_last   <= emit_last;
            r_status <= r_st;
        end
    end

    assign o_valid  = r_out_v;
    assign o_letter = r_letter;
    assign o_last   = r_last;
    assign o_status = r_status;

endmodule

`default_nettype wire

FILE: hw/rtl/rne_checker.sv
// ----------------------------------------------------------------------------
// rne_checker
// Port-level checks on the encoder's input and output words, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rne_checker (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  wire logic                         o_stall,
    input  wire logic [rne_pkg::NUM_W-1:0]    i_number,
    input  wire logic                         o_valid,
    input  wire logic                         i_stall,
    input  wire logic [rne_pkg::LETTER_W-1:0] o_letter,
    input  wire logic                         o_last,
    input  wire logic [1:0]                   o_status
);
    import rne_pkg::*;

    // hold a stalled input word
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_number))
        else $error("input word changed while stalled");

    // hold a stalled word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_letter) && $stable(o_last)
                               && $stable(o_status))
        else $error("output word changed while stalled");

    // a status word stands alone and carries no letter
    a_status_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_last && o_letter == CH_NONE)
        else $error("status word without last or with a letter");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status == ST_OK || o_status == ST_EMPTY || o_status == ST_RANGE)
        else $error("undefined status code");

    a_letter_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_OK |->
            o_letter == CH_I || o_letter == CH_V || o_letter == CH_X ||
            o_letter == CH_L || o_letter == CH_C || o_letter == CH_D ||
            o_letter == CH_M)
        else $error("ok word carries a non-Roman letter");

endmodule

bind roman_numeral_encoder_unit rne_checker u_rne_checker (.*);

`default_nettype wire
